FILE: hw/rtl/qpim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpim_pkg
// Shared widths and types of the quad point inside / inverse map pipeline.
// ----------------------------------------------------------------------------
package qpim_pkg;

  localparam int unsigned IN_W    = 32;
  localparam int unsigned NODES   = 4;
  localparam int unsigned FIELDS  = 2 * NODES + 2;
  localparam int unsigned CF_W    = 34;
  localparam int unsigned PX_W    = 35;
  localparam int unsigned PR_W    = 70;
  localparam int unsigned WD_W    = 72;
  localparam int unsigned HALF_W  = 36;
  localparam int unsigned SQ_W    = 144;
  localparam int unsigned DISC_W  = 148;
  localparam int unsigned RAD_PAD = 32;
  localparam int unsigned RAD_W   = SQ_W + RAD_PAD;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned VN_W    = 90;
  localparam int unsigned VD_W    = 73;
  localparam int unsigned Q_W     = 18;
  localparam int unsigned UV_W    = 18;
  localparam int unsigned UD_W    = 54;
  localparam int unsigned UN_W    = UD_W + FRAC_W;
  localparam int unsigned LIM_W   = 32;
  localparam int unsigned LIM_SH  = 4;
  localparam int unsigned OUT_W   = 40;

  localparam logic [Q_W-1:0] UV_ONE = Q_W'(1) << FRAC_W;

  typedef struct packed {
    logic signed [CF_W-1:0] bx;
    logic signed [CF_W-1:0] cx;
    logic signed [CF_W-1:0] dx;
    logic signed [PX_W-1:0] px;
  } geo_t;

  typedef struct packed {
    geo_t            geo;
    logic            ok;
    logic            lin;
    logic            disc_neg;
    logic            bq_neg;
    logic [WD_W-1:0] bq_mag;
    logic            a_neg;
    logic [WD_W-1:0] a_mag;
    logic            cq_neg;
    logic [WD_W-1:0] cq_mag;
  } coef_t;

  typedef struct packed {
    geo_t geo;
    logic lin;
    logic go_p;
    logic go_m;
    logic sgn_p;
  } vt_t;

  typedef struct packed {
    logic signed [UV_W-1:0] v_p;
    logic signed [UV_W-1:0] v_m;
    logic                   ok_p;
    logic                   ok_m;
    logic                   sgn_p;
  } ut_t;

endpackage

FILE: hw/rtl/qpim_coef.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpim_coef
// Bounding box test, bilinear coefficients, quadratic terms and discriminant.
// ----------------------------------------------------------------------------
module qpim_coef import qpim_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [FIELDS*IN_W-1:0]  data_i,
  input  logic [LIM_W-1:0]        lim_i,
  output logic                    valid_o,
  output coef_t                   coef_o,
  output logic [SQ_W-1:0]         rad_o
);

  logic signed [IN_W-1:0] x [NODES];
  logic signed [IN_W-1:0] y [NODES];
  logic signed [IN_W-1:0] qx, qy;
  logic                   bb_ok;
  logic signed [CF_W-1:0] sx, sy;
  geo_t                   geo_d;
  logic signed [CF_W-1:0] by_d, cy_d, dy_d;
  logic signed [PX_W-1:0] py_d;
  logic                   xl, xh, yl, yh;

  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      x[i] = data_i[i*IN_W +: IN_W];
      y[i] = data_i[(NODES+i)*IN_W +: IN_W];
    end
    qx = data_i[2*NODES*IN_W +: IN_W];
    qy = data_i[(2*NODES+1)*IN_W +: IN_W];
    xl = 1'b0;
    xh = 1'b0;
    yl = 1'b0;
    yh = 1'b0;
    for (int i = 0; i < NODES; i++) begin
      xl = xl | (qx >= x[i]);
      xh = xh | (qx <= x[i]);
      yl = yl | (qy >= y[i]);
      yh = yh | (qy <= y[i]);
    end
    bb_ok = xl & xh & yl & yh;
    sx = CF_W'(x[0]) + CF_W'(x[1]) + CF_W'(x[2]) + CF_W'(x[3]);
    sy = CF_W'(y[0]) + CF_W'(y[1]) + CF_W'(y[2]) + CF_W'(y[3]);
    geo_d.bx = -CF_W'(x[0]) + CF_W'(x[1]) + CF_W'(x[2]) - CF_W'(x[3]);
    geo_d.cx = -CF_W'(x[0]) - CF_W'(x[1]) + CF_W'(x[2]) + CF_W'(x[3]);
    geo_d.dx = CF_W'(x[0]) - CF_W'(x[1]) + CF_W'(x[2]) - CF_W'(x[3]);
    geo_d.px = (PX_W'(qx) <<< 2) - PX_W'(sx);
    by_d = -CF_W'(y[0]) + CF_W'(y[1]) + CF_W'(y[2]) - CF_W'(y[3]);
    cy_d = -CF_W'(y[0]) - CF_W'(y[1]) + CF_W'(y[2]) + CF_W'(y[3]);
    dy_d = CF_W'(y[0]) - CF_W'(y[1]) + CF_W'(y[2]) - CF_W'(y[3]);
    py_d = (PX_W'(qy) <<< 2) - PX_W'(sy);
  end

  // stage 1: coefficients
  logic                   v1_q;
  geo_t                   g1_q;
  logic                   ok1_q;
  logic signed [CF_W-1:0] by1_q, cy1_q, dy1_q;
  logic signed [PX_W-1:0] py1_q;

  // stage 2: products
  logic                   v2_q;
  geo_t                   g2_q;
  logic                   ok2_q;
  logic signed [PR_W-1:0] p_q [8];
  logic signed [PR_W-1:0] p_d [8];

  // stage 3: quadratic coefficients
  logic                   v3_q;
  geo_t                   g3_q;
  logic                   ok3_q;
  logic signed [WD_W-1:0] a3_q, b3_q, c3_q;

  // stage 4: magnitudes and partial products
  logic                   v4_q;
  coef_t                  k4_q, k4_d;
  logic [2*HALF_W-1:0]    bb_q [3];
  logic [2*HALF_W-1:0]    ac_q [4];
  logic [2*HALF_W-1:0]    bb_d [3];
  logic [2*HALF_W-1:0]    ac_d [4];
  logic                   acn4_q;

  // stage 5: square and cross term
  logic                   v5_q;
  coef_t                  k5_q;
  logic [SQ_W-1:0]        sq5_q, ac5_q;
  logic                   acn5_q;

  // stage 6: discriminant
  logic                   v6_q;
  coef_t                  k6_q;
  logic [SQ_W-1:0]        rad6_q;

  logic signed [DISC_W-1:0] disc_d, ac4x;

  always_comb begin
    p_d[0] = cy1_q * g1_q.dx;
    p_d[1] = g1_q.cx * dy1_q;
    p_d[2] = g1_q.bx * cy1_q;
    p_d[3] = by1_q * g1_q.cx;
    p_d[4] = dy1_q * g1_q.px;
    p_d[5] = g1_q.dx * py1_q;
    p_d[6] = by1_q * g1_q.px;
    p_d[7] = g1_q.bx * py1_q;
  end

  always_comb begin
    k4_d.geo      = g3_q;
    k4_d.ok       = ok3_q;
    k4_d.a_neg    = a3_q[WD_W-1];
    k4_d.a_mag    = a3_q[WD_W-1] ? WD_W'(-a3_q) : WD_W'(a3_q);
    k4_d.bq_neg   = b3_q[WD_W-1];
    k4_d.bq_mag   = b3_q[WD_W-1] ? WD_W'(-b3_q) : WD_W'(b3_q);
    k4_d.cq_neg   = c3_q[WD_W-1];
    k4_d.cq_mag   = c3_q[WD_W-1] ? WD_W'(-c3_q) : WD_W'(c3_q);
    k4_d.lin      = k4_d.a_mag <= (WD_W'(lim_i) << LIM_SH);
    k4_d.disc_neg = 1'b0;
    bb_d[0] = k4_d.bq_mag[HALF_W-1:0] * k4_d.bq_mag[HALF_W-1:0];
    bb_d[1] = k4_d.bq_mag[HALF_W-1:0] * k4_d.bq_mag[WD_W-1:HALF_W];
    bb_d[2] = k4_d.bq_mag[WD_W-1:HALF_W] * k4_d.bq_mag[WD_W-1:HALF_W];
    ac_d[0] = k4_d.a_mag[HALF_W-1:0] * k4_d.cq_mag[HALF_W-1:0];
    ac_d[1] = k4_d.a_mag[HALF_W-1:0] * k4_d.cq_mag[WD_W-1:HALF_W];
    ac_d[2] = k4_d.a_mag[WD_W-1:HALF_W] * k4_d.cq_mag[HALF_W-1:0];
    ac_d[3] = k4_d.a_mag[WD_W-1:HALF_W] * k4_d.cq_mag[WD_W-1:HALF_W];
  end

  always_comb begin
    ac4x   = signed'({2'b00, ac5_q, 2'b00});
    disc_d = signed'({4'b0000, sq5_q}) - (acn5_q ? -ac4x : ac4x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q   <= geo_d;
      ok1_q  <= bb_ok;
      by1_q  <= by_d;
      cy1_q  <= cy_d;
      dy1_q  <= dy_d;
      py1_q  <= py_d;
      g2_q   <= g1_q;
      ok2_q  <= ok1_q;
      p_q    <= p_d;
      g3_q   <= g2_q;
      ok3_q  <= ok2_q;
      a3_q   <= p_q[0] - p_q[1];
      b3_q   <= p_q[2] - p_q[3] + p_q[4] - p_q[5];
      c3_q   <= p_q[6] - p_q[7];
      k4_q   <= k4_d;
      bb_q   <= bb_d;
      ac_q   <= ac_d;
      acn4_q <= k4_d.a_neg ^ k4_d.cq_neg;
      k5_q   <= k4_q;
      sq5_q  <= (SQ_W'(bb_q[2]) << (2*HALF_W)) + (SQ_W'(bb_q[1]) << (HALF_W+1))
                + SQ_W'(bb_q[0]);
      ac5_q  <= (SQ_W'(ac_q[3]) << (2*HALF_W)) + (SQ_W'(ac_q[1]) << HALF_W)
                + (SQ_W'(ac_q[2]) << HALF_W) + SQ_W'(ac_q[0]);
      acn5_q <= acn4_q;
      k6_q   <= '{geo: k5_q.geo, ok: k5_q.ok, lin: k5_q.lin,
                  disc_neg: disc_d[DISC_W-1], bq_neg: k5_q.bq_neg, bq_mag: k5_q.bq_mag,
                  a_neg: k5_q.a_neg, a_mag: k5_q.a_mag, cq_neg: k5_q.cq_neg,
                  cq_mag: k5_q.cq_mag};
      rad6_q <= disc_d[SQ_W-1:0];
    end
  end

  assign valid_o = v6_q;
  assign coef_o  = k6_q;
  assign rad_o   = rad6_q;

endmodule

FILE: hw/rtl/qpim_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpim_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qpim_sqrt import qpim_pkg::*; #(
  parameter int unsigned TAG_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   rad_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic              vld_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [TAG_W-1:0]  tag_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              vld_in;
    logic [REM_W-1:0]  rem_in, rem2, trial;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [TAG_W-1:0]  tag_in;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {rad_i, {RAD_PAD{1'b0}}};
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    assign rem2  = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign take  = rem2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? rem2 - trial : rem2;
        root_q[k] <= {root_in[ROOT_W-2:0], take};
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        tag_q[k]  <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign tag_o   = tag_q[ROOT_W-1];

endmodule

FILE: hw/rtl/qpim_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpim_div
// Pipelined restoring divider for a short quotient with overflow flag.
// ----------------------------------------------------------------------------
module qpim_div import qpim_pkg::*; #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned TW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [TW-1:0]  tag_i,
  output logic           valid_o,
  output logic [Q_W-1:0] quo_o,
  output logic           ovf_o,
  output logic [TW-1:0]  tag_o
);

  localparam int unsigned RW = (NW > DW + Q_W) ? NW : DW + Q_W;

  logic           vld_q [Q_W+1];
  logic [RW-1:0]  r_q   [Q_W+1];
  logic [DW-1:0]  d_q   [Q_W+1];
  logic [Q_W-1:0] q_q   [Q_W+1];
  logic           ovf_q [Q_W+1];
  logic [TW-1:0]  tag_q [Q_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= RW'(num_i);
      d_q[0]   <= den_i;
      q_q[0]   <= '0;
      ovf_q[0] <= RW'(num_i) >= (RW'(den_i) << Q_W);
      tag_q[0] <= tag_i;
    end
  end

  for (genvar j = 1; j <= Q_W; j++) begin : g_bit
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = RW'(d_q[j-1]) << (Q_W - j);
    assign ge = r_q[j-1] >= sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j]   <= ge ? r_q[j-1] - sh : r_q[j-1];
        d_q[j]   <= d_q[j-1];
        q_q[j]   <= q_q[j-1] | (Q_W'(ge) << (Q_W - j));
        ovf_q[j] <= ovf_q[j-1];
        tag_q[j] <= tag_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[Q_W];
  assign quo_o   = q_q[Q_W];
  assign ovf_o   = ovf_q[Q_W];
  assign tag_o   = tag_q[Q_W];

endmodule

FILE: hw/rtl/quad_point_inside_inverse_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_point_inside_inverse_map_unit
// Point in bilinear quadrilateral test with inverse map to element u, v.
// ----------------------------------------------------------------------------
// Takes one word per cycle while s_axis_tready is high and returns one result
// word per input word, in order. The path runs through the square root of the
// discriminant (88 stages, one root bit each) and through the two divider
// pipelines for v and for u (19 stages each); the plus and minus roots run in
// parallel lanes. While a result waits at the output, input words are still
// taken as long as the pipeline has a free slot at its end.
module quad_point_inside_inverse_map_unit import qpim_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // node_x0..node_x3, node_y0..node_y3, point_x, point_y
  input  logic [FIELDS*IN_W-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // inside_res, u_coord, v_coord, zero pad
  output logic [OUT_W-1:0]       m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [LIM_W-1:0]       cfg_wdata_i
);

  logic [LIM_W-1:0] lim_q;
  logic             en, load, last_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= '0;
    end else if (cfg_we_i) begin
      lim_q <= cfg_wdata_i;
    end
  end

  // coefficients and discriminant
  logic            cf_vld;
  coef_t           cf;
  logic [SQ_W-1:0] cf_rad;

  qpim_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .data_i  (s_axis_tdata),
    .lim_i   (lim_q),
    .valid_o (cf_vld),
    .coef_o  (cf),
    .rad_o   (cf_rad)
  );

  logic                  sr_vld;
  logic [ROOT_W-1:0]     sr_root;
  logic [$bits(coef_t)-1:0] sr_tag;
  coef_t                 sk;

  qpim_sqrt #(.TAG_W($bits(coef_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cf_vld),
    .rad_i   (cf_rad),
    .tag_i   (cf),
    .valid_o (sr_vld),
    .root_o  (sr_root),
    .tag_o   (sr_tag)
  );

  assign sk = coef_t'(sr_tag);

  // v numerators and divisors
  logic signed [VN_W:0] bqs, sn, sw, np, nm;
  logic [VN_W-1:0]      np_mag, nm_mag, ln_mag;
  logic [VD_W-1:0]      dq, ld;
  vt_t                  vt_d, vt_q;
  logic                 v0_q, sgn_m_d, sgn_m_q;
  logic [VN_W-1:0]      np_q, nm_q, np_d;
  logic [VD_W-1:0]      dp_q, dm_q, dp_d;

  always_comb begin
    bqs    = signed'({3'b000, sk.bq_mag, {FRAC_W{1'b0}}});
    sn     = sk.bq_neg ? bqs : -bqs;
    sw     = signed'({3'b000, sr_root});
    np     = sn + sw;
    nm     = sn - sw;
    np_mag = np[VN_W] ? VN_W'(-np) : VN_W'(np);
    nm_mag = nm[VN_W] ? VN_W'(-nm) : VN_W'(nm);
    ln_mag = {2'b00, sk.cq_mag, {FRAC_W{1'b0}}};
    dq     = {sk.a_mag, 1'b0};
    ld     = {1'b0, sk.bq_mag};
    np_d   = sk.lin ? ln_mag : np_mag;
    dp_d   = sk.lin ? ld : dq;
    vt_d.geo   = sk.geo;
    vt_d.lin   = sk.lin;
    vt_d.go_p  = sk.ok & (sk.lin ? (sk.bq_mag != '0) : !sk.disc_neg);
    vt_d.go_m  = sk.ok & !sk.lin & !sk.disc_neg;
    vt_d.sgn_p = sk.lin ? (!sk.cq_neg ^ sk.bq_neg) : (np[VN_W] ^ sk.a_neg);
    sgn_m_d    = nm[VN_W] ^ sk.a_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= sr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      np_q    <= np_d;
      dp_q    <= dp_d;
      nm_q    <= nm_mag;
      dm_q    <= dq;
      vt_q    <= vt_d;
      sgn_m_q <= sgn_m_d;
    end
  end

  logic                 vdp_vld, vdp_ovf, vdm_ovf, vdm_sgn;
  logic [Q_W-1:0]       vdp_q, vdm_q;
  logic [$bits(vt_t)-1:0] vdp_tag;
  vt_t                  vr;

  qpim_div #(.NW(VN_W), .DW(VD_W), .TW($bits(vt_t))) u_vdiv_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .num_i   (np_q),
    .den_i   (dp_q),
    .tag_i   (vt_q),
    .valid_o (vdp_vld),
    .quo_o   (vdp_q),
    .ovf_o   (vdp_ovf),
    .tag_o   (vdp_tag)
  );

  qpim_div #(.NW(VN_W), .DW(VD_W), .TW(1)) u_vdiv_m (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .num_i   (nm_q),
    .den_i   (dm_q),
    .tag_i   (sgn_m_q),
    .valid_o (),
    .quo_o   (vdm_q),
    .ovf_o   (vdm_ovf),
    .tag_o   (vdm_sgn)
  );

  assign vr = vt_t'(vdp_tag);

  // u setup: products, sums, magnitudes
  logic signed [UV_W-1:0] vp_d, vm_d;
  logic                   vokp_d, vokm_d;

  always_comb begin
    vp_d   = vr.sgn_p ? -signed'(vdp_q) : signed'(vdp_q);
    vm_d   = vdm_sgn ? -signed'(vdm_q) : signed'(vdm_q);
    vokp_d = vr.go_p & !vdp_ovf & (vr.lin ? (vdp_q < UV_ONE) : (vdp_q <= UV_ONE));
    vokm_d = vr.go_m & !vdm_ovf & (vdm_q <= UV_ONE);
  end

  logic                   u0_q, u1_q, u2_q;
  logic signed [UV_W-1:0] vp0_q, vm0_q, vp1_q, vm1_q, vp2_q, vm2_q;
  logic                   okp0_q, okm0_q, okp1_q, okm1_q;
  logic signed [CF_W-1:0] bx0_q;
  logic signed [PX_W-1:0] px0_q;
  logic signed [UD_W-1:0] dxp0_q, cxp0_q, dxm0_q, cxm0_q;
  logic signed [UD_W-1:0] denp1_q, nump1_q, denm1_q, numm1_q;
  logic [UN_W-1:0]        unp2_q, unm2_q;
  logic [UD_W-1:0]        udp2_q, udm2_q;
  logic                   okp2_q, okm2_q, sgp2_q, sgm2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u0_q <= 1'b0;
      u1_q <= 1'b0;
      u2_q <= 1'b0;
    end else if (en) begin
      u0_q <= vdp_vld;
      u1_q <= u0_q;
      u2_q <= u1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vp0_q   <= vp_d;
      vm0_q   <= vm_d;
      okp0_q  <= vokp_d;
      okm0_q  <= vokm_d;
      bx0_q   <= vr.geo.bx;
      px0_q   <= vr.geo.px;
      dxp0_q  <= vr.geo.dx * vp_d;
      cxp0_q  <= vr.geo.cx * vp_d;
      dxm0_q  <= vr.geo.dx * vm_d;
      cxm0_q  <= vr.geo.cx * vm_d;
      vp1_q   <= vp0_q;
      vm1_q   <= vm0_q;
      okp1_q  <= okp0_q;
      okm1_q  <= okm0_q;
      denp1_q <= (UD_W'(bx0_q) <<< FRAC_W) + dxp0_q;
      nump1_q <= (UD_W'(px0_q) <<< FRAC_W) - cxp0_q;
      denm1_q <= (UD_W'(bx0_q) <<< FRAC_W) + dxm0_q;
      numm1_q <= (UD_W'(px0_q) <<< FRAC_W) - cxm0_q;
      vp2_q   <= vp1_q;
      vm2_q   <= vm1_q;
      okp2_q  <= okp1_q & (denp1_q != '0);
      okm2_q  <= okm1_q & (denm1_q != '0);
      sgp2_q  <= denp1_q[UD_W-1] ^ nump1_q[UD_W-1];
      sgm2_q  <= denm1_q[UD_W-1] ^ numm1_q[UD_W-1];
      udp2_q  <= denp1_q[UD_W-1] ? UD_W'(-denp1_q) : UD_W'(denp1_q);
      udm2_q  <= denm1_q[UD_W-1] ? UD_W'(-denm1_q) : UD_W'(denm1_q);
      unp2_q  <= {(nump1_q[UD_W-1] ? UD_W'(-nump1_q) : UD_W'(nump1_q)), {FRAC_W{1'b0}}};
      unm2_q  <= {(numm1_q[UD_W-1] ? UD_W'(-numm1_q) : UD_W'(numm1_q)), {FRAC_W{1'b0}}};
    end
  end

  ut_t                  ut_d;
  logic [$bits(ut_t)-1:0] udp_tag;
  ut_t                  ur;
  logic                 udp_vld, udp_ovf, udm_ovf, udm_sgn;
  logic [Q_W-1:0]       udp_q, udm_q;

  assign ut_d = '{v_p: vp2_q, v_m: vm2_q, ok_p: okp2_q, ok_m: okm2_q, sgn_p: sgp2_q};

  qpim_div #(.NW(UN_W), .DW(UD_W), .TW($bits(ut_t))) u_udiv_p (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (u2_q),
    .num_i   (unp2_q),
    .den_i   (udp2_q),
    .tag_i   (ut_d),
    .valid_o (udp_vld),
    .quo_o   (udp_q),
    .ovf_o   (udp_ovf),
    .tag_o   (udp_tag)
  );

  qpim_div #(.NW(UN_W), .DW(UD_W), .TW(1)) u_udiv_m (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (u2_q),
    .num_i   (unm2_q),
    .den_i   (udm2_q),
    .tag_i   (sgm2_q),
    .valid_o (),
    .quo_o   (udm_q),
    .ovf_o   (udm_ovf),
    .tag_o   (udm_sgn)
  );

  assign ur = ut_t'(udp_tag);

  // root selection and output word
  logic signed [UV_W-1:0] up_d, um_d, u_sel, v_sel;
  logic                   okp_d, okm_d;
  logic                   out_vld_q, out_in_q;
  logic [UV_W-1:0]        out_u_q, out_v_q;

  always_comb begin
    up_d  = ur.sgn_p ? -signed'(udp_q) : signed'(udp_q);
    um_d  = udm_sgn ? -signed'(udm_q) : signed'(udm_q);
    okp_d = ur.ok_p & !udp_ovf & (udp_q <= UV_ONE);
    okm_d = ur.ok_m & !udm_ovf & (udm_q <= UV_ONE);
    if (okp_d) begin
      u_sel = up_d;
      v_sel = ur.v_p;
    end else if (okm_d) begin
      u_sel = um_d;
      v_sel = ur.v_m;
    end else begin
      u_sel = '0;
      v_sel = '0;
    end
  end

  assign last_vld = udp_vld;
  assign load     = !out_vld_q | m_axis_tready;
  assign en       = load | !last_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= last_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && last_vld) begin
      out_in_q <= okp_d | okm_d;
      out_u_q  <= u_sel;
      out_v_q  <= v_sel;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_W - 1 - 2*UV_W){1'b0}}, out_v_q, out_u_q, out_in_q};

endmodule
